@@ design/nsng_pkg.sv @@
package nsng_pkg;

   // Width of the requested position field.
   localparam int unsigned COUNT_WIDTH = 12;

   // Number of multiplier lanes and the prime that each lane multiplies by.
   localparam int unsigned LANES = 3;
   localparam int unsigned LANE_MULT [LANES] = '{2, 3, 5};

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;     // load a new request and seed the fill
      logic step;      // generate one more table entry
      logic load_out;  // copy the finished answer into the output register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic more;      // entries remain to be generated for this request
      logic last;      // the step taken now generates the final entry
   } status_type;

endpackage

@@ design/nsng_controller.sv @@
module nsng_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output nsng_pkg::cmd_type    cmd,
   input  nsng_pkg::status_type status
);
   import nsng_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_FILL = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Sequencing of one item: seed, fill the table, then hand the answer over.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_FILL;
            end
         end
         ST_FILL: begin
            cmd.step = status.more;
            if (!status.more || status.last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and output valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ design/nsng_datapath.sv @@
module nsng_datapath #(
   parameter int unsigned MAX_COUNT   = 2048,
   parameter int unsigned VALUE_WIDTH = 48
) (
   input  logic                             clock,
   input  logic [nsng_pkg::COUNT_WIDTH-1:0] req_count_wanted,
   input  nsng_pkg::cmd_type                cmd,
   output nsng_pkg::status_type             status,
   output logic [VALUE_WIDTH-1:0]           rsp_smooth_value,
   output logic                             rsp_range_error
);
   import nsng_pkg::*;

   localparam int unsigned AW = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1;
   localparam int unsigned PW = $clog2(MAX_COUNT + 1);
   localparam int unsigned W  = VALUE_WIDTH;

   logic [PW-1:0] n_ff;
   logic [PW-1:0] n_in;
   logic [PW-1:0] pos_ff;
   logic [PW-1:0] pos_in;
   logic          err_ff;
   logic          err_in;
   logic [W-1:0]  result_ff;
   logic [W-1:0]  result_in;
   logic [W-1:0]  out_value_ff;
   logic          out_err_ff;
   logic [W-1:0]  pend_ff [LANES];
   logic [W-1:0]  low_01;
   logic [W-1:0]  low;

   // Range check of the incoming position.
   assign err_in = (req_count_wanted == '0) ||
                   ({1'b0, req_count_wanted} > (COUNT_WIDTH + 1)'(MAX_COUNT));

   // Smallest of the three pending multiples is the next table entry.
   assign low_01 = (pend_ff[1] < pend_ff[0]) ? pend_ff[1] : pend_ff[0];
   assign low    = (pend_ff[2] < low_01) ? pend_ff[2] : low_01;

   // Fill bookkeeping.
   always_comb begin
      n_in      = n_ff;
      pos_in    = pos_ff;
      result_in = result_ff;
      if (cmd.start) begin
         n_in      = PW'(req_count_wanted);
         pos_in    = PW'(1);
         result_in = err_in ? '0 : W'(1);
      end else if (cmd.step) begin
         pos_in    = pos_ff + PW'(1);
         result_in = low;
      end
   end

   assign status.more = !err_ff && (pos_ff < n_ff);
   assign status.last = ((pos_ff + PW'(1)) == n_ff);

   always_ff @(posedge clock) begin
      n_ff      <= n_in;
      pos_ff    <= pos_in;
      result_ff <= result_in;
      if (cmd.start) begin
         err_ff <= err_in;
      end
      if (cmd.load_out) begin
         out_value_ff <= result_ff;
         out_err_ff   <= err_ff;
      end
   end

   assign rsp_smooth_value = out_value_ff;
   assign rsp_range_error  = out_err_ff;

   // One lane per prime: its pointer, pending multiple and a private copy of the table,
   // so that each pointer has a read port of its own.
   for (genvar k = 0; k < LANES; k++) begin : g_lane
      localparam int unsigned MULT = LANE_MULT[k];

      logic [W-1:0]  value_mem [MAX_COUNT];
      logic [AW-1:0] idx_ff;
      logic [AW-1:0] idx_in;
      logic [W-1:0]  pend_in;
      logic [W-1:0]  rd_ff;
      logic [PW-1:0] nxt_pos;
      logic [PW-1:0] rd_pos;
      logic [W-1:0]  src;
      logic [W-1:0]  prod;
      logic          adv;

      assign adv     = cmd.step && (low == pend_ff[k]);
      assign nxt_pos = PW'(idx_ff) + PW'(1);

      // The entry after the pointer may be the one written now or in the previous
      // cycle, in which case the memory read is stale and the value is forwarded.
      always_comb begin
         if (nxt_pos == pos_ff) begin
            src = low;
         end else if (nxt_pos == (pos_ff - PW'(1))) begin
            src = result_ff;
         end else begin
            src = rd_ff;
         end
      end

      // Multiplication by a small prime as shift and add, modulo the value width.
      always_comb begin
         if (MULT == 2) begin
            prod = src << 1;
         end else if (MULT == 3) begin
            prod = (src << 1) + src;
         end else begin
            prod = (src << 2) + src;
         end
      end

      always_comb begin
         idx_in  = idx_ff;
         pend_in = pend_ff[k];
         if (cmd.start) begin
            idx_in  = '0;
            pend_in = W'(MULT);
         end else if (adv) begin
            idx_in  = idx_ff + AW'(1);
            pend_in = prod;
         end
      end

      // Prefetch the entry after the pointer's next position.
      assign rd_pos = PW'(idx_in) + PW'(1);

      always_ff @(posedge clock) begin
         idx_ff     <= idx_in;
         pend_ff[k] <= pend_in;
         rd_ff      <= value_mem[rd_pos[AW-1:0]];
         if (cmd.step) begin
            value_mem[pos_ff[AW-1:0]] <= low;
         end
      end
   end

endmodule

@@ design/nth_smooth_number_generator.sv @@
// Returns the n-th number whose only prime factors are 2, 3 and 5 (1 is the first), for
// n from 1 to MAX_COUNT; any other n gives range_error with a value of 0. Each item
// regenerates the table from its first entry, one entry per clock, through three
// pointers with their own table copies. A result still waiting in the output register
// holds the answer back for as long as it waits. The next item can be accepted in the
// cycle after the answer is loaded, while the previous result still waits in the output
// register. Values are VALUE_WIDTH bits and wrap modulo 2^VALUE_WIDTH.
module nth_smooth_number_generator #(
   parameter int unsigned MAX_COUNT   = 2048,
   parameter int unsigned VALUE_WIDTH = 48
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [nsng_pkg::COUNT_WIDTH-1:0] req_count_wanted,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [VALUE_WIDTH-1:0]           rsp_smooth_value,
   output logic                             rsp_range_error
);
   import nsng_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer for one item at a time.
   nsng_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Table, pointers and output register.
   nsng_datapath #(
      .MAX_COUNT   (MAX_COUNT),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .req_count_wanted (req_count_wanted),
      .cmd              (cmd),
      .status           (status),
      .rsp_smooth_value (rsp_smooth_value),
      .rsp_range_error  (rsp_range_error)
   );

endmodule

@@ design/nsng_checker.sv @@
module nsng_checker #(
   parameter int unsigned VALUE_WIDTH = 48
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [VALUE_WIDTH-1:0]           rsp_smooth_value,
   input logic                             rsp_range_error
);

   // A stalled result item holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_smooth_value) &&
                                  $stable(rsp_range_error))
      else $error("result item changed while stalled");

   // A flagged item carries a value of zero.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_range_error |-> rsp_smooth_value == '0)
      else $error("range error with non-zero value");

   // A good item is never zero, as the sequence starts at one.
   a_good_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_range_error |-> rsp_smooth_value != '0)
      else $error("good result item of zero");

   // The block works on one item at a time, so acceptance drops ready.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready stayed high after an item was accepted");

endmodule

bind nth_smooth_number_generator nsng_checker #(
   .VALUE_WIDTH (VALUE_WIDTH)
) u_nsng_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_smooth_value (rsp_smooth_value),
   .rsp_range_error  (rsp_range_error)
);

@@ bench/smooth_checker.sv @@
module smooth_checker #(
   parameter int unsigned MAX_COUNT   = 2048,
   parameter int unsigned VALUE_WIDTH = 48
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic [nsng_pkg::COUNT_WIDTH-1:0] req_count_wanted,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [VALUE_WIDTH-1:0]           rsp_smooth_value,
   input  logic                             rsp_range_error,
   output int unsigned                      failures,
   output int unsigned                      awaited,
   output int unsigned                      answered,
   output int unsigned                      flagged
);
   timeunit 1ns;
   timeprecision 1ps;

   // One predicted answer, kept with the position that asked for it.
   typedef struct packed {
      logic [nsng_pkg::COUNT_WIDTH-1:0] count;
      logic [VALUE_WIDTH-1:0]           value;
      logic                             range_error;
   } smooth_answer_type;

   smooth_answer_type answers_due [$];

   // Own copy of the generator state: the table, the three pointers and their
   // pending multiples, and the position reached by the last fill.
   logic [VALUE_WIDTH-1:0] hamming_table [MAX_COUNT];
   int unsigned            ptr_two;
   int unsigned            ptr_three;
   int unsigned            ptr_five;
   logic [VALUE_WIDTH-1:0] next_two;
   logic [VALUE_WIDTH-1:0] next_three;
   logic [VALUE_WIDTH-1:0] next_five;
   int unsigned            last_fill;

   int unsigned mismatch_count = 0;
   int unsigned answered_count = 0;
   int unsigned flagged_count  = 0;

   // Refills the table from entry 0 up to position n and returns entry n-1.
   // A position of zero or beyond the table leaves the state untouched.
   function automatic smooth_answer_type nth_smooth(
      input logic [nsng_pkg::COUNT_WIDTH-1:0] n);
      smooth_answer_type      answer;
      logic [VALUE_WIDTH-1:0] lowest;
      int unsigned            pos;
      answer.count = n;
      if (n == 0 || n > MAX_COUNT) begin
         answer.value       = '0;
         answer.range_error = 1'b1;
         return answer;
      end
      hamming_table[0] = 1;
      ptr_two    = 0;
      ptr_three  = 0;
      ptr_five   = 0;
      next_two   = 2;
      next_three = 3;
      next_five  = 5;
      for (pos = 1; pos < n; pos++) begin
         lowest = next_two;
         if (next_three < lowest) lowest = next_three;
         if (next_five < lowest) lowest = next_five;
         hamming_table[pos] = lowest;
         // Every lane that produced the new entry moves on, which drops duplicates.
         if (lowest == next_two) begin
            ptr_two++;
            next_two = hamming_table[ptr_two] * 2;
         end
         if (lowest == next_three) begin
            ptr_three++;
            next_three = hamming_table[ptr_three] * 3;
         end
         if (lowest == next_five) begin
            ptr_five++;
            next_five = hamming_table[ptr_five] * 5;
         end
      end
      last_fill          = 32'(n);
      answer.value       = hamming_table[n - 1];
      answer.range_error = 1'b0;
      return answer;
   endfunction

   // Counts a failure; only the first ten are described.
   task automatic note_failure(input string what);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t ns: %s", $time, what);
   endtask

   // Results are matched before new requests are queued, so an item that
   // arrives in the same cycle as a result never overtakes an older one.
   always @(posedge clock) begin : watch_channels
      smooth_answer_type due;
      if (reset) begin
         answers_due.delete();
         ptr_two    = 0;
         ptr_three  = 0;
         ptr_five   = 0;
         next_two   = 2;
         next_three = 3;
         next_five  = 5;
         last_fill  = 1;
      end else begin
         if (rsp_valid && rsp_ready) begin
            answered_count++;
            if (rsp_range_error) flagged_count++;
            if (answers_due.size() == 0) begin
               note_failure($sformatf("result value %0d, range_error %0b, nothing waiting",
                                      rsp_smooth_value, rsp_range_error));
            end else begin
               due = answers_due.pop_front();
               if (rsp_smooth_value !== due.value)
                  note_failure($sformatf("n=%0d smooth_value: expected %0d, got %0d",
                                         due.count, due.value, rsp_smooth_value));
               if (rsp_range_error !== due.range_error)
                  note_failure($sformatf("n=%0d range_error: expected %0b, got %0b",
                                         due.count, due.range_error, rsp_range_error));
            end
         end
         if (req_valid && req_ready)
            answers_due.push_back(nth_smooth(req_count_wanted));
      end
      failures <= mismatch_count;
      awaited  <= answers_due.size();
      answered <= answered_count;
      flagged  <= flagged_count;
   end

endmodule

@@ bench/tb.sv @@
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MAX_COUNT       = 2048;
   localparam int unsigned VALUE_WIDTH     = 48;
   localparam int unsigned CW              = nsng_pkg::COUNT_WIDTH;
   localparam int unsigned RANDOM_ITEMS    = 268;
   localparam int unsigned QUIET_ITEMS     = 30;
   localparam int unsigned HOLD_OFF_AFTER  = 40;
   localparam int unsigned HOLD_OFF_CYCLES = 600;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [CW-1:0]          req_count_wanted;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [VALUE_WIDTH-1:0] rsp_smooth_value;
   logic                   rsp_range_error;

   int unsigned failures;
   int unsigned awaited;
   int unsigned answered;
   int unsigned flagged;
   int unsigned sent          = 0;
   int unsigned largest_count = 0;
   logic        quiet         = 1'b0;

   nth_smooth_number_generator #(
      .MAX_COUNT  (MAX_COUNT),
      .VALUE_WIDTH(VALUE_WIDTH)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_count_wanted(req_count_wanted),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_smooth_value(rsp_smooth_value),
      .rsp_range_error (rsp_range_error)
   );

   smooth_checker #(
      .MAX_COUNT  (MAX_COUNT),
      .VALUE_WIDTH(VALUE_WIDTH)
   ) i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_count_wanted(req_count_wanted),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_smooth_value(rsp_smooth_value),
      .rsp_range_error (rsp_range_error),
      .failures        (failures),
      .awaited         (awaited),
      .answered        (answered),
      .flagged         (flagged)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Even the slowest correct run finishes well inside this bound.
   initial begin
      #20_000_000;
      $display("tb failed");
      $finish;
   end

   // Mostly short fills, some medium, a few near the top of the table, some out
   // of range and some taken from the whole field.
   function automatic logic [CW-1:0] pick_count();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return CW'($urandom_range(1, 40));
      if (r < 72) return CW'($urandom_range(41, 300));
      if (r < 78) return CW'($urandom_range(301, 1000));
      if (r < 80) return CW'($urandom_range(1500, MAX_COUNT));
      if (r < 84) return '0;
      if (r < 92) return CW'($urandom_range(MAX_COUNT + 1, (1 << CW) - 1));
      return CW'($urandom_range(0, (1 << CW) - 1));
   endfunction

   // Offers one item and returns at the edge that accepts it; valid stays high.
   task automatic offer_count(input logic [CW-1:0] n);
      req_valid        <= 1'b1;
      req_count_wanted <= n;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
      if (n >= 1 && n <= MAX_COUNT && n > largest_count) largest_count = 32'(n);
   endtask

   // Now and then the sender pauses, with junk on the payload while idle.
   task automatic idle_sender();
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid        <= 1'b0;
         req_count_wanted <= CW'($urandom);
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   // Result side: random stalls in choppy windows, calm windows in between, and
   // one long hold-off so that the block fills up and pushes back on its input.
   initial begin : result_side
      int unsigned window_left;
      bit          choppy;
      bit          held;
      window_left = 0;
      choppy      = 1'b0;
      held        = 1'b0;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (window_left == 0) begin
            window_left = $urandom_range(20, 80);
            choppy      = $urandom_range(0, 2) != 0;
         end
         window_left--;
         if (!held && answered >= HOLD_OFF_AFTER) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (choppy && !quiet && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Request side: directed positions first, then the random mix.
   initial begin : request_side
      int unsigned directed_counts [$] = '{
         1, 2, 3, 4, 5, 6, 7, 8, 0, 15, 16, 100, MAX_COUNT, MAX_COUNT + 1, 4095,
         MAX_COUNT - 1, 1690, 1691, 1692, 12'h555, 12'hAAA, 1, 0
      };
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_count_wanted <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_counts[k]) begin
         offer_count(CW'(directed_counts[k]));
         idle_sender();
      end

      // The last stretch runs with no idling on either side.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i >= RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
         offer_count(pick_count());
         idle_sender();
      end
      req_valid <= 1'b0;

      // Drain, then allow one full fill's time for any stray result to show.
      @(posedge clock);
      while (awaited != 0) @(posedge clock);
      repeat (MAX_COUNT + 16) @(posedge clock);

      $display("Sent %0d requests (%0d directed), largest in-range position %0d.",
               sent, directed_counts.size(), largest_count);
      $display("Checked %0d results, %0d of them flagged out of range; %0d failures.",
               answered, flagged, failures);
      if (failures == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule
